// ===== design/assert_macros.svh =====
// assertion macros used by voxel_grid_downsample
// no dependencies; the including module must have i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define VGD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked implication, disabled while reset is asserted
`define VGD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vgd_pkg.sv =====
// shared types, constants and the division helper function of the voxel grid downsampler
// no dependencies
package vgd_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_PROBE_DEF   = 8;

    localparam int KEY_W   = 23;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 16;
    localparam int COORD_W = 32;
    localparam int SCALE_W = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd1310720;
    localparam logic [SCALE_W-1:0] SCALE_LIMIT = 24'd6553600;
    localparam logic [16:0]        HASH_MUL    = 17'd116101;
    localparam logic [CNT_W-1:0]   COUNT_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        STAT_NEW   = 3'd0,
        STAT_ACC   = 3'd1,
        STAT_DROP  = 3'd2,
        STAT_DRAIN = 3'd3,
        STAT_EMPTY = 3'd4,
        STAT_OFF   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_HASH1,
        ST_HASH2,
        ST_ISSUE,
        ST_PROBE,
        ST_WRITE,
        ST_DSCAN,
        ST_DIV,
        ST_DIVOUT
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] kx;
        logic signed [KEY_W-1:0] ky;
        logic signed [KEY_W-1:0] kz;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [CNT_W-1:0]        cnt;
    } t_slot;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] quo;
    } t_div;

    // one restoring division step: shift in a dividend bit, subtract if possible
    function automatic t_div div_step(t_div cur, logic [CNT_W-1:0] dvsr);
        logic [CNT_W:0] trial;
        t_div           res;
        trial   = {cur.rem, cur.quo[SUM_W-1]};
        res.quo = {cur.quo[SUM_W-2:0], 1'b0};
        if (trial >= {1'b0, dvsr}) begin
            res.rem    = CNT_W'(trial - {1'b0, dvsr});
            res.quo[0] = 1'b1;
        end else begin
            res.rem = trial[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/vgd_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module vgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/voxel_grid_downsample.sv =====
// voxel grid centroid downsampler: hash table of voxel sums in one ram
// depends on vgd_pkg, vgd_ram and assert_macros.svh
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-----------------------------------------
//  command   | start, busy              | i_op, i_px, i_py, i_pz
//  result    | o_valid (one-cycle pulse)| o_status, o_mean_*, o_point_count, o_last
//  config    | i_cfg_we                 | i_cfg_data (voxel scale)
//
// insert: multiply, hash and read issue, then one ram read per probed slot
// (1 to MAX_PROBE), then a write unless dropped; the result follows in the next cycle.
// drain: one ram read per scanned slot from the drain pointer, then the three restoring
// divider lanes and an output state; a scan that finds no valid slot ends empty.
// after reset a clearing pass writes every slot with busy high.
// results cannot be stalled; the table size must be a power of two.
`include "assert_macros.svh"

module voxel_grid_downsample
    import vgd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_PROBE   = MAX_PROBE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_op,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_pz,
    input  logic                      i_cfg_we,
    input  logic [SCALE_W-1:0]        i_cfg_data,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic signed [COORD_W-1:0] o_mean_x,
    output logic signed [COORD_W-1:0] o_mean_y,
    output logic signed [COORD_W-1:0] o_mean_z,
    output logic [CNT_W-1:0]          o_point_count,
    output logic                      o_last
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int IW     = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
    localparam int SLOT_W = $bits(t_slot);
    localparam int PROD_W = COORD_W + SCALE_W + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [AW-1:0] MUL_A = AW'(HASH_MUL);

    t_state r_state, n_state;

    logic [SCALE_W-1:0]        r_scale;
    logic [AW:0]               r_clr;
    logic [AW:0]               r_occ;
    logic [AW-1:0]             r_dptr;
    logic signed [COORD_W-1:0] r_c [3];
    logic signed [PROD_W-1:0]  r_p [3];
    logic [AW-1:0]             r_t;
    logic [AW-1:0]             r_base;
    logic [AW-1:0]             r_slot;
    logic [AW-1:0]             r_cnt;
    logic [IW-1:0]             r_i;
    logic                      r_have_free;
    logic [AW-1:0]             r_free;
    logic                      r_match;
    logic [AW-1:0]             r_wslot;
    t_slot                     r_word;
    t_div                      r_div [3];
    logic                      r_neg [3];
    logic [CNT_W-1:0]          r_dvsr;
    logic [CNT_W-1:0]          r_dcount;
    logic [STEP_W-1:0]         r_dstep;

    logic                      r_stb;
    logic [2:0]                r_status;
    logic signed [COORD_W-1:0] r_mean [3];
    logic [CNT_W-1:0]          r_pcnt;
    logic                      r_last;

    logic                      accept;
    logic                      disabled;
    logic signed [KEY_W-1:0]   key [3];
    t_slot                     rd;
    logic                      hit;
    logic                      free_now;
    logic [AW-1:0]             free_slot;
    logic                      last_probe;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    t_slot                     ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [SLOT_W-1:0]         ram_rdata;
    logic                      fin;
    t_status                   fin_stat;
    logic signed [COORD_W-1:0] fin_mean [3];
    logic [CNT_W-1:0]          fin_cnt;
    logic                      fin_last;

    vgd_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign disabled = (r_scale > SCALE_LIMIT);
    assign rd       = t_slot'(ram_rdata);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            key[j] = r_p[j][COORD_W+KEY_W-1:COORD_W];
        end
    end

    assign hit = rd.valid && (rd.kx == key[0]) && (rd.ky == key[1]) && (rd.kz == key[2]);
    assign free_now   = r_have_free || !rd.valid;
    assign free_slot  = r_have_free ? r_free : r_slot;
    assign last_probe = (r_i == IW'(MAX_PROBE - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == (AW+1)'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && !disabled) begin
                    if (!i_op) n_state = ST_MUL;
                    else if (r_occ != '0) n_state = ST_DSCAN;
                end
            end
            ST_MUL:   n_state = ST_HASH1;
            ST_HASH1: n_state = ST_HASH2;
            ST_HASH2: n_state = ST_ISSUE;
            ST_ISSUE: n_state = ST_PROBE;
            ST_PROBE: begin
                if (hit) n_state = ST_WRITE;
                else if (last_probe) n_state = free_now ? ST_WRITE : ST_IDLE;
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_DSCAN: begin
                if (rd.valid) n_state = ST_DIV;
                else if (r_cnt == AW'(TABLE_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (r_dstep == STEP_W'(SUM_W - 1)) n_state = ST_DIVOUT;
            end
            ST_DIVOUT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ram control and result selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wslot;
        ram_wdata = r_word;
        ram_raddr = AW'(r_slot + 1'b1);
        fin       = 1'b0;
        fin_stat  = STAT_NEW;
        fin_cnt   = '0;
        fin_last  = 1'b0;
        for (int j = 0; j < 3; j++) fin_mean[j] = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr[AW-1:0];
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_raddr = r_dptr;
                if (accept) begin
                    if (disabled) begin
                        fin      = 1'b1;
                        fin_stat = STAT_OFF;
                    end else if (i_op && r_occ == '0) begin
                        fin      = 1'b1;
                        fin_stat = STAT_EMPTY;
                    end
                end
            end
            ST_ISSUE: ram_raddr = r_base;
            ST_PROBE: begin
                if (!hit && last_probe && !free_now) begin
                    fin      = 1'b1;
                    fin_stat = STAT_DROP;
                end
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                fin    = 1'b1;
                if (r_match) begin
                    fin_stat = STAT_ACC;
                    if (r_word.cnt != COUNT_MAX) begin
                        ram_wdata.sx  = r_word.sx + SUM_W'(r_c[0]);
                        ram_wdata.sy  = r_word.sy + SUM_W'(r_c[1]);
                        ram_wdata.sz  = r_word.sz + SUM_W'(r_c[2]);
                        ram_wdata.cnt = r_word.cnt + 1'b1;
                    end
                end else begin
                    fin_stat        = STAT_NEW;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.kx    = key[0];
                    ram_wdata.ky    = key[1];
                    ram_wdata.kz    = key[2];
                    ram_wdata.sx    = SUM_W'(r_c[0]);
                    ram_wdata.sy    = SUM_W'(r_c[1]);
                    ram_wdata.sz    = SUM_W'(r_c[2]);
                    ram_wdata.cnt   = CNT_W'(1);
                end
            end
            ST_DSCAN: begin
                if (rd.valid) begin
                    // free the slot being drained
                    ram_we          = 1'b1;
                    ram_waddr       = r_slot;
                    ram_wdata       = rd;
                    ram_wdata.valid = 1'b0;
                end else if (r_cnt == AW'(TABLE_DEPTH - 1)) begin
                    fin      = 1'b1;
                    fin_stat = STAT_EMPTY;
                end
            end
            ST_DIVOUT: begin
                fin      = 1'b1;
                fin_stat = STAT_DRAIN;
                fin_cnt  = r_dcount;
                fin_last = (r_occ == '0);
                for (int j = 0; j < 3; j++) begin
                    fin_mean[j] = r_neg[j] ? COORD_W'(-r_div[j].quo)
                                           : COORD_W'(r_div[j].quo);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_scale <= SCALE_RESET;
            r_clr   <= '0;
            r_occ   <= '0;
            r_dptr  <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stb   <= fin;
            if (i_cfg_we) r_scale <= i_cfg_data;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_WRITE && !r_match) r_occ <= r_occ + 1'b1;
            if (r_state == ST_DSCAN) begin
                if (rd.valid) begin
                    r_occ  <= r_occ - 1'b1;
                    r_dptr <= AW'(r_slot + 1'b1);
                end else if (r_cnt == AW'(TABLE_DEPTH - 1)) begin
                    r_occ <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status <= fin_stat;
            r_pcnt   <= fin_cnt;
            r_last   <= fin_last;
            for (int j = 0; j < 3; j++) r_mean[j] <= fin_mean[j];
        end
        case (r_state)
            ST_IDLE: begin
                r_c[0] <= i_px;
                r_c[1] <= i_py;
                r_c[2] <= i_pz;
                r_slot <= r_dptr;
                r_cnt  <= '0;
            end
            ST_MUL: begin
                for (int j = 0; j < 3; j++) begin
                    r_p[j] <= PROD_W'(r_c[j] * $signed({1'b0, r_scale}));
                end
            end
            ST_HASH1: r_t    <= key[2][AW-1:0] * MUL_A + key[1][AW-1:0];
            ST_HASH2: r_base <= r_t * MUL_A + key[0][AW-1:0];
            ST_ISSUE: begin
                r_slot      <= r_base;
                r_i         <= '0;
                r_have_free <= 1'b0;
            end
            ST_PROBE: begin
                if (hit) begin
                    r_match <= 1'b1;
                    r_wslot <= r_slot;
                    r_word  <= rd;
                end else begin
                    r_have_free <= free_now;
                    r_free      <= free_slot;
                    r_match     <= 1'b0;
                    r_wslot     <= free_slot;
                    r_i         <= r_i + 1'b1;
                    r_slot      <= AW'(r_slot + 1'b1);
                end
            end
            ST_DSCAN: begin
                r_slot <= AW'(r_slot + 1'b1);
                r_cnt  <= r_cnt + 1'b1;
                // load divider lanes with sum magnitudes
                r_div[0] <= '{rem: '0, quo: rd.sx[SUM_W-1] ? SUM_W'(-rd.sx) : SUM_W'(rd.sx)};
                r_div[1] <= '{rem: '0, quo: rd.sy[SUM_W-1] ? SUM_W'(-rd.sy) : SUM_W'(rd.sy)};
                r_div[2] <= '{rem: '0, quo: rd.sz[SUM_W-1] ? SUM_W'(-rd.sz) : SUM_W'(rd.sz)};
                r_neg[0] <= rd.sx[SUM_W-1];
                r_neg[1] <= rd.sy[SUM_W-1];
                r_neg[2] <= rd.sz[SUM_W-1];
                r_dvsr   <= (rd.cnt == '0) ? CNT_W'(1) : rd.cnt;
                r_dcount <= rd.cnt;
                r_dstep  <= '0;
            end
            ST_DIV: begin
                for (int j = 0; j < 3; j++) r_div[j] <= div_step(r_div[j], r_dvsr);
                r_dstep <= r_dstep + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_stb;
    assign o_status      = r_status;
    assign o_mean_x      = r_mean[0];
    assign o_mean_y      = r_mean[1];
    assign o_mean_z      = r_mean[2];
    assign o_point_count = r_pcnt;
    assign o_last        = r_last;

    `VGD_ASSERT(a_occ_bound, r_occ <= (AW+1)'(TABLE_DEPTH), "occupied count beyond table size")
    `VGD_ASSERT_IMP(a_accept_progress, start && !busy, busy || o_valid, "accepted command lost")
    `VGD_ASSERT(a_drain_count, !(o_valid && o_status == STAT_DRAIN) || o_point_count != '0,
        "drained voxel with no points")
    `VGD_ASSERT_IMP(a_write_from_probe, r_state == ST_WRITE, o_valid, "insert write without result")

endmodule

// ===== sim/tb_voxel_grid_downsample.sv =====
// testbench for voxel_grid_downsample: directed and random insert and drain transactions
// depends on vgd_pkg and the design files; checks every result against a built-in predictor
`timescale 1ns / 100ps

module tb_voxel_grid_downsample;
    import vgd_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;
    localparam int   DEPTH     = 4096;
    localparam int   PROBES    = 8;
    localparam int   WDOG_MAX  = 20000;

    typedef struct {
        t_status          st;
        logic [31:0]      mx;
        logic [31:0]      my;
        logic [31:0]      mz;
        logic [15:0]      pc;
        logic             lst;
    } t_voxel_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = 1'b0;
    logic [31:0] i_px = '0;
    logic [31:0] i_py = '0;
    logic [31:0] i_pz = '0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_mean_x;
    logic [31:0] o_mean_y;
    logic [31:0] o_mean_z;
    logic [15:0] o_point_count;
    logic        o_last;

    voxel_grid_downsample dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_px          (i_px),
        .i_py          (i_py),
        .i_pz          (i_pz),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_mean_x      (o_mean_x),
        .o_mean_y      (o_mean_y),
        .o_mean_z      (o_mean_z),
        .o_point_count (o_point_count),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the voxel table
    bit            vt_valid [DEPTH];
    longint        vt_kx [DEPTH], vt_ky [DEPTH], vt_kz [DEPTH];
    longint        vt_sx [DEPTH], vt_sy [DEPTH], vt_sz [DEPTH];
    int unsigned   vt_cnt [DEPTH];
    int unsigned   vt_drain_ptr = 0;
    int unsigned   vt_occupied = 0;
    logic [23:0]   scale_reg = SCALE_RESET;

    t_voxel_result pending_results[$];
    int            error_count = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            drains_seen = 0;
    int            wdog = 0;
    bit            no_idle = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic longint voxel_index(longint coord, logic [23:0] scale);
        longint p;
        p = coord * longint'({40'd0, scale});
        if (p >= 0) return p >>> 32;
        return -(((-p) + 64'sh0FFFF_FFFF) >>> 32);
    endfunction

    function automatic t_voxel_result status_only(t_status st);
        t_voxel_result r;
        r.st = st;
        r.mx = '0;
        r.my = '0;
        r.mz = '0;
        r.pc = '0;
        r.lst = 1'b0;
        return r;
    endfunction

    function automatic t_voxel_result predict_voxel_op(logic op, logic [31:0] x,
                                                       logic [31:0] y, logic [31:0] z);
        t_voxel_result r;
        longint        cx, cy, cz, kx, ky, kz, n;
        logic [63:0]   h;
        int unsigned   s, free_slot;
        bit            have_free;
        cx = longint'(signed'(x));
        cy = longint'(signed'(y));
        cz = longint'(signed'(z));
        have_free = 1'b0;
        free_slot = 0;
        if (scale_reg > SCALE_LIMIT) return status_only(STAT_OFF);
        if (op == OP_DRAIN) begin
            if (vt_occupied == 0) return status_only(STAT_EMPTY);
            for (int i = 0; i < DEPTH; i++) begin
                s = (vt_drain_ptr + i) % DEPTH;
                if (vt_valid[s]) begin
                    n = (vt_cnt[s] != 0) ? longint'(vt_cnt[s]) : 1;
                    r.st = STAT_DRAIN;
                    r.mx = 32'(vt_sx[s] / n);
                    r.my = 32'(vt_sy[s] / n);
                    r.mz = 32'(vt_sz[s] / n);
                    r.pc = 16'(vt_cnt[s]);
                    vt_valid[s] = 1'b0;
                    vt_occupied--;
                    r.lst = (vt_occupied == 0);
                    vt_drain_ptr = (s + 1) % DEPTH;
                    return r;
                end
            end
            vt_occupied = 0;
            return status_only(STAT_EMPTY);
        end
        kx = voxel_index(cx, scale_reg);
        ky = voxel_index(cy, scale_reg);
        kz = voxel_index(cz, scale_reg);
        h = (64'(kz) * 64'd116101 + 64'(ky)) * 64'd116101 + 64'(kx);
        for (int i = 0; i < PROBES; i++) begin
            s = (int'(h[11:0]) + i) % DEPTH;
            if (vt_valid[s]) begin
                if (vt_kx[s] == kx && vt_ky[s] == ky && vt_kz[s] == kz) begin
                    if (vt_cnt[s] < 65535) begin
                        vt_sx[s] += cx;
                        vt_sy[s] += cy;
                        vt_sz[s] += cz;
                        vt_cnt[s]++;
                    end
                    return status_only(STAT_ACC);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = s;
            end
        end
        if (!have_free) return status_only(STAT_DROP);
        vt_valid[free_slot] = 1'b1;
        vt_kx[free_slot] = kx;
        vt_ky[free_slot] = ky;
        vt_kz[free_slot] = kz;
        vt_sx[free_slot] = cx;
        vt_sy[free_slot] = cy;
        vt_sz[free_slot] = cz;
        vt_cnt[free_slot] = 1;
        vt_occupied++;
        return status_only(STAT_NEW);
    endfunction

    // start stays high across back-to-back transactions
    task automatic send_item(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        t_voxel_result exp_r;
        if (!no_idle) begin
            while ($urandom_range(99) < 15) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_op <= op;
        i_px <= x;
        i_py <= y;
        i_pz <= z;
        do @(posedge i_clk); while (busy);
        exp_r = predict_voxel_op(op, x, y, z);
        pending_results.insert(pending_results.size(), exp_r);
        items_sent++;
    endtask

    task automatic settle_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [23:0] v);
        settle_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scale_reg = v;
    endtask

    task automatic drain_table();
        while (vt_occupied != 0 && scale_reg <= SCALE_LIMIT)
            send_item(OP_DRAIN, $urandom, $urandom, $urandom);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_voxel_result e;
        if (o_valid || (start && !busy)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("[%0t] unexpected result, status %0d", $realtime, o_status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_status == STAT_DRAIN) drains_seen++;
                if (o_status != e.st) report_mismatch("status", 32'(o_status), 32'(e.st));
                if (o_mean_x != e.mx) report_mismatch("mean_x", o_mean_x, e.mx);
                if (o_mean_y != e.my) report_mismatch("mean_y", o_mean_y, e.my);
                if (o_mean_z != e.mz) report_mismatch("mean_z", o_mean_z, e.mz);
                if (o_point_count != e.pc)
                    report_mismatch("point_count", 32'(o_point_count), 32'(e.pc));
                if (o_last != e.lst) report_mismatch("last", 32'(o_last), 32'(e.lst));
            end
        end
    end

    function automatic logic [31:0] cluster_coord(int c);
        return 32'(c * 40000 - 100000 + $signed($urandom_range(4000)) - 2000);
    endfunction

    task automatic test_field_extremes();
        send_item(OP_DRAIN, '0, '0, '0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_item(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
        send_item(OP_INSERT, 32'hFFFF_0000, 32'hFFFF_0001, 32'h5555_AAAA);
        drain_table();
        send_item(OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // unit scale: keys that differ by multiples of the table depth share a probe window
    task automatic test_probe_overflow();
        write_scale(24'd65536);
        for (int n = -1; n < 8; n++)
            send_item(OP_INSERT, 32'(n * 32'h1000_0000), '0, '0);
        send_item(OP_INSERT, 32'h2000_0000, '0, '0);
        for (int n = 0; n < 3; n++)
            send_item(OP_INSERT, 32'((4095 + n * 4096) * 65536), '0, '0);
        drain_table();
        // freed slot ahead of a live key must not hide it
        send_item(OP_INSERT, '0, '0, '0);
        send_item(OP_INSERT, 32'h1000_0000, '0, '0);
        send_item(OP_DRAIN, '0, '0, '0);
        send_item(OP_INSERT, 32'h1000_0000, '0, '0);
        drain_table();
    endtask

    task automatic test_disable_and_zero_scale();
        write_scale(24'd6553601);
        send_item(OP_INSERT, 32'h0001_0000, '0, '0);
        send_item(OP_DRAIN, '0, '0, '0);
        write_scale(24'hFF_FFFF);
        send_item(OP_INSERT, 32'h1234_5678, '0, '0);
        write_scale(SCALE_LIMIT);
        send_item(OP_INSERT, 32'h0000_0123, 32'hFFFF_FF00, '0);
        write_scale(24'd0);
        send_item(OP_INSERT, 32'h7000_0000, 32'h9000_0000, 32'h1);
        send_item(OP_INSERT, 32'h8000_0001, 32'h7000_0000, 32'hFFFF_FFFF);
        drain_table();
    endtask

    // many random points merged back to back into a single voxel
    task automatic test_single_voxel_merge();
        write_scale(24'd0);
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_INSERT, $urandom, $urandom, $urandom);
        no_idle = 1'b0;
        drain_table();
    endtask

    task automatic test_random_traffic();
        logic [23:0] scales [6];
        int          c;
        scales = '{SCALE_RESET, 24'd65536, 24'd1, SCALE_LIMIT, 24'd3000000, 24'd7000000};
        for (int ph = 0; ph < 6; ph++) begin
            write_scale(scales[ph]);
            no_idle = (ph == 1);
            for (int i = 0; i < 70; i++) begin
                if (i == 40) settle_idle();
                c = $urandom_range(5);
                if ($urandom_range(99) < 25)
                    send_item(OP_DRAIN, $urandom, $urandom, $urandom);
                else if ($urandom_range(99) < 10)
                    send_item(OP_INSERT, $urandom, $urandom, $urandom);
                else
                    send_item(OP_INSERT, cluster_coord(c), cluster_coord(c),
                              cluster_coord(5 - c));
            end
            no_idle = 1'b0;
        end
        write_scale(SCALE_RESET);
        drain_table();
        send_item(OP_DRAIN, '0, '0, '0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_probe_overflow();
        test_disable_and_zero_scale();
        test_single_voxel_merge();
        test_random_traffic();
        settle_idle();
        repeat (50) @(posedge i_clk);
        $display("sent %0d transactions, checked %0d results (%0d voxel drains)",
                 items_sent, results_seen, drains_seen);
        $display("covered probe overflow, disable, zero scale, single-voxel merge, random scales");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/vgd_pkg.sv
design/vgd_ram.sv
design/voxel_grid_downsample.sv
sim/tb_voxel_grid_downsample.sv
